// ===== hw/rtl/hrb_pkg.sv =====
`default_nettype none
package hrb_pkg;

    localparam int BUFFER_DEPTH_DEF = 1024;
    localparam int STATE_WORDS_DEF  = 4;
    localparam int HISTORY_MAX_DEF  = 4;

    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int HIST_W      = 3;
    localparam int FRAME_SLOTS = 8;
    localparam int SLOT_IDX_W  = 3;
    localparam int FCNT_W      = 4;
    localparam int RND_W       = 16;
    localparam int DIVC_W      = 5;
    localparam int ACTION_W    = 16;
    localparam int DATA_W      = 32;
    localparam int META_W      = ACTION_W + DATA_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'b1;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_RECENT = 2'd2;

    localparam logic [1:0] KIND_HIST   = 2'd0;
    localparam logic [1:0] KIND_NEXT   = 2'd1;
    localparam logic [1:0] KIND_RECENT = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_OLDER,
        ST_META,
        ST_RINIT,
        ST_WALK,
        ST_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_ERR,
        ST_EMIT_WAIT
    } hrb_state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic set_sample;
        logic set_recent;
        logic load_meta;
        logic walk_issue;
        logic walk_pad;
        logic walk_check;
        logic emit_issue;
        logic emit_load;
        logic err_load;
        logic emit_advance;
    } hrb_cmd_t;

    typedef struct packed {
        logic [1:0] in_act;
        logic       fill_zero;
        logic       recent_final;
        logic       div_done;
        logic       walk_done;
        logic       walk_can_read;
        logic       out_taken;
        logic       out_last;
    } hrb_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hrb_in_if.sv =====
`default_nettype none
interface hrb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] state_word;
    logic [15:0] taken_action;
    logic [31:0] reward_bits;
    logic        done_flag;
    logic [15:0] random_value;

    modport source (output valid, action, state_word, taken_action, reward_bits, done_flag,
                    random_value, input ready);
    modport sink (input valid, action, state_word, taken_action, reward_bits, done_flag,
                  random_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hrb_out_if.sv =====
`default_nettype none
interface hrb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  frame_slot;
    logic [1:0]  word_index;
    logic [31:0] data_word;
    logic [15:0] sample_action;
    logic [31:0] sample_reward;
    logic        sample_done;
    logic        last;

    modport source (output valid, kind, frame_slot, word_index, data_word, sample_action,
                    sample_reward, sample_done, last, input ready);
    modport sink (input valid, kind, frame_slot, word_index, data_word, sample_action,
                  sample_reward, sample_done, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hrb_ram.sv =====
`default_nettype none
module hrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/hrb_ctrl.sv =====
`default_nettype none
module hrb_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hrb_pkg::hrb_status_t status,
    output hrb_pkg::hrb_cmd_t        cmd
);

    hrb_pkg::hrb_state_t state_reg;
    hrb_pkg::hrb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hrb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.in_act == hrb_pkg::ACT_SAMPLE)
                    begin
                        state_next = status.fill_zero ? hrb_pkg::ST_ERR : hrb_pkg::ST_DIV;
                    end
                    else if (status.recent_final)
                    begin
                        state_next = hrb_pkg::ST_RINIT;
                    end
                end
            end
            hrb_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = hrb_pkg::ST_OLDER;
                end
            end
            hrb_pkg::ST_OLDER:     state_next = hrb_pkg::ST_META;
            hrb_pkg::ST_META:      state_next = hrb_pkg::ST_WALK;
            hrb_pkg::ST_RINIT:     state_next = hrb_pkg::ST_WALK;
            hrb_pkg::ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = hrb_pkg::ST_EMIT_RD;
                end
                else if (status.walk_can_read)
                begin
                    state_next = hrb_pkg::ST_CHK;
                end
            end
            hrb_pkg::ST_CHK:       state_next = hrb_pkg::ST_WALK;
            hrb_pkg::ST_EMIT_RD:   state_next = hrb_pkg::ST_EMIT_LD;
            hrb_pkg::ST_EMIT_LD:   state_next = hrb_pkg::ST_EMIT_WAIT;
            hrb_pkg::ST_ERR:       state_next = hrb_pkg::ST_EMIT_WAIT;
            hrb_pkg::ST_EMIT_WAIT:
            begin
                if (status.out_taken)
                begin
                    state_next = status.out_last ? hrb_pkg::ST_IDLE : hrb_pkg::ST_EMIT_RD;
                end
            end
            default:               state_next = hrb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            hrb_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            hrb_pkg::ST_DIV:       cmd.div_step = !status.div_done;
            hrb_pkg::ST_OLDER:     cmd.set_sample = 1'b1;
            hrb_pkg::ST_META:      cmd.load_meta = 1'b1;
            hrb_pkg::ST_RINIT:     cmd.set_recent = 1'b1;
            hrb_pkg::ST_WALK:
            begin
                if (!status.walk_done)
                begin
                    cmd.walk_issue = status.walk_can_read;
                    cmd.walk_pad   = !status.walk_can_read;
                end
            end
            hrb_pkg::ST_CHK:       cmd.walk_check = 1'b1;
            hrb_pkg::ST_EMIT_RD:   cmd.emit_issue = 1'b1;
            hrb_pkg::ST_EMIT_LD:   cmd.emit_load = 1'b1;
            hrb_pkg::ST_ERR:       cmd.err_load = 1'b1;
            hrb_pkg::ST_EMIT_WAIT: cmd.emit_advance = status.out_taken;
            default:               cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/hrb_dp.sv =====
`default_nettype none
module hrb_dp #(
    parameter int BUFFER_DEPTH = hrb_pkg::BUFFER_DEPTH_DEF,
    parameter int STATE_WORDS  = hrb_pkg::STATE_WORDS_DEF,
    parameter int HISTORY_MAX  = hrb_pkg::HISTORY_MAX_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    hrb_in_if.sink                                 items,
    hrb_out_if.source                              results,
    input  wire logic                              wr_en,
    input  wire logic [hrb_pkg::CFG_IDX_W-1:0]     wr_index,
    input  wire logic [hrb_pkg::CFG_DATA_W-1:0]    wr_data,
    input  wire hrb_pkg::hrb_cmd_t                 cmd,
    output hrb_pkg::hrb_status_t                   status
);

    localparam int PTR_W   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W   = PTR_W + 1;
    localparam int WORD_W  = (STATE_WORDS > 1) ? $clog2(STATE_WORDS) : 1;
    localparam int SADDR_W = $clog2(BUFFER_DEPTH * STATE_WORDS);
    localparam int FW      = hrb_pkg::FCNT_W;
    localparam int SW      = hrb_pkg::SLOT_IDX_W;
    localparam logic [CNT_W-1:0]  CAP_MAX   = CNT_W'(BUFFER_DEPTH);
    localparam logic [CNT_W-1:0]  CAP_RESET = CNT_W'((BUFFER_DEPTH < 1024) ? BUFFER_DEPTH : 1024);
    localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(STATE_WORDS - 1);
    localparam logic [FW-1:0]     HIST_TOP  = FW'(HISTORY_MAX);

    function automatic logic [SADDR_W-1:0] state_addr(input logic [PTR_W-1:0] entry,
                                                      input logic [WORD_W-1:0] word);
        state_addr = SADDR_W'(SADDR_W'(entry) * SADDR_W'(STATE_WORDS)) + SADDR_W'(word);
    endfunction

    logic [hrb_pkg::HIST_W-1:0] hist_reg;
    logic [CNT_W-1:0]           cap_reg;
    logic [PTR_W-1:0]           wp_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic [WORD_W-1:0]          add_wc_reg;
    logic [WORD_W-1:0]          rec_wc_reg;
    logic [31:0]                curbuf_reg [STATE_WORDS];

    logic [hrb_pkg::RND_W-1:0]  rnd_reg;
    logic [CNT_W-1:0]           rem_reg;
    logic [hrb_pkg::DIVC_W-1:0] divc_reg;

    logic [PTR_W-1:0]           pos_reg;
    logic [PTR_W-1:0]           prev_reg;
    logic [PTR_W-1:0]           nxt_reg;
    logic [CNT_W-1:0]           avail_reg;
    logic                       stopped_reg;
    logic [FW-1:0]              j_reg;
    logic [PTR_W-1:0]           sel_idx_reg [hrb_pkg::FRAME_SLOTS];
    logic                       sel_ok_reg  [hrb_pkg::FRAME_SLOTS];
    logic                       recent_reg;
    logic                       zero_next_reg;
    logic [15:0]                meta_act_reg;
    logic [31:0]                meta_rew_reg;
    logic                       meta_done_reg;

    logic                       phase_reg;
    logic [FW-1:0]              f_reg;
    logic [WORD_W-1:0]          w_reg;

    logic                       out_valid_reg;
    logic [1:0]                 out_kind_reg;
    logic [1:0]                 out_slot_reg;
    logic [1:0]                 out_word_reg;
    logic [31:0]                out_data_reg;
    logic [15:0]                out_act_reg;
    logic [31:0]                out_rew_reg;
    logic                       out_done_reg;
    logic                       out_last_reg;

    logic [FW-1:0]              h_eff;
    logic [CNT_W-1:0]           cap_val;
    logic                       add_we;
    logic                       add_last;
    logic [CNT_W:0]             div_t;
    logic [PTR_W-1:0]           s_val;
    logic [CNT_W:0]             older_t;
    logic [CNT_W-1:0]           older_val;
    logic [PTR_W-1:0]           prev_val;
    logic [SW-1:0]              walk_slot;
    logic                       last_frame;
    logic                       src_cur;
    logic                       e_ok;
    logic [PTR_W-1:0]           e_idx;
    logic                       emit_last;
    logic [PTR_W-1:0]           entry_raddr;
    logic [hrb_pkg::META_W-1:0] entry_rdata;
    logic [31:0]                state_rdata;
    logic                       out_taken;

    always_comb
    begin
        if (hist_reg == '0)
        begin
            h_eff = FW'(1);
        end
        else if (FW'(hist_reg) > HIST_TOP)
        begin
            h_eff = HIST_TOP;
        end
        else
        begin
            h_eff = FW'(hist_reg);
        end

        if (wr_data == '0)
        begin
            cap_val = CNT_W'(1);
        end
        else if (32'(wr_data) > 32'(BUFFER_DEPTH))
        begin
            cap_val = CAP_MAX;
        end
        else
        begin
            cap_val = CNT_W'(wr_data);
        end
    end

    assign add_we   = cmd.accept && (items.action == hrb_pkg::ACT_ADD);
    assign add_last = (add_wc_reg == WORD_LAST);

    assign div_t = {rem_reg, rnd_reg[hrb_pkg::RND_W-1]};
    assign s_val = PTR_W'(rem_reg);

    always_comb
    begin
        older_t = CNT_W'(s_val) + {1'b0, cap_reg} - CNT_W'(wp_reg);
        if (older_t >= {1'b0, cap_reg})
        begin
            older_t = older_t - {1'b0, cap_reg};
        end
        older_val = (fill_reg == cap_reg) ? CNT_W'(older_t) : CNT_W'(s_val);
    end

    assign prev_val    = (pos_reg == '0) ? PTR_W'(cap_reg - CNT_W'(1)) : pos_reg - PTR_W'(1);
    assign walk_slot   = SW'(h_eff - FW'(2) - j_reg);
    assign last_frame  = (f_reg == h_eff - FW'(1));
    assign entry_raddr = cmd.set_sample ? s_val : prev_val;

    always_comb
    begin
        src_cur = 1'b0;
        e_ok    = sel_ok_reg[SW'(f_reg)];
        e_idx   = sel_idx_reg[SW'(f_reg)];
        if (!phase_reg)
        begin
            src_cur = recent_reg && last_frame;
        end
        else if (zero_next_reg)
        begin
            e_ok = 1'b0;
        end
        else if (last_frame)
        begin
            e_ok  = 1'b1;
            e_idx = nxt_reg;
        end
        else
        begin
            e_ok  = sel_ok_reg[SW'(f_reg + FW'(1))];
            e_idx = sel_idx_reg[SW'(f_reg + FW'(1))];
        end
    end

    assign emit_last = (w_reg == WORD_LAST) && last_frame && (recent_reg || phase_reg);
    assign out_taken = out_valid_reg && results.ready;

    hrb_ram #(
        .WIDTH (32),
        .DEPTH (BUFFER_DEPTH * STATE_WORDS)
    ) u_state_ram (
        .clk   (clk),
        .we    (add_we),
        .waddr (state_addr(wp_reg, add_wc_reg)),
        .wdata (items.state_word),
        .raddr (state_addr(e_idx, w_reg)),
        .rdata (state_rdata)
    );

    hrb_ram #(
        .WIDTH (hrb_pkg::META_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (add_we && add_last),
        .waddr (wp_reg),
        .wdata ({items.taken_action, items.reward_bits, items.done_flag}),
        .raddr (entry_raddr),
        .rdata (entry_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg      <= hrb_pkg::HIST_W'(4);
            cap_reg       <= CAP_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            add_wc_reg    <= '0;
            rec_wc_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == hrb_pkg::REG_HISTORY_LEN)
                begin
                    hist_reg <= wr_data[hrb_pkg::HIST_W-1:0];
                end
                else
                begin
                    cap_reg    <= cap_val;
                    wp_reg     <= '0;
                    fill_reg   <= '0;
                    add_wc_reg <= '0;
                end
            end
            else if (add_we)
            begin
                if (add_last)
                begin
                    add_wc_reg <= '0;
                    wp_reg     <= (CNT_W'(wp_reg) + CNT_W'(1) == cap_reg) ? '0
                                  : wp_reg + PTR_W'(1);
                    if (fill_reg < cap_reg)
                    begin
                        fill_reg <= fill_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    add_wc_reg <= add_wc_reg + WORD_W'(1);
                end
            end

            if (cmd.accept && (items.action == hrb_pkg::ACT_RECENT))
            begin
                rec_wc_reg <= (rec_wc_reg == WORD_LAST) ? '0 : rec_wc_reg + WORD_W'(1);
            end

            if (cmd.emit_load || cmd.err_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (items.action == hrb_pkg::ACT_RECENT))
        begin
            curbuf_reg[rec_wc_reg] <= items.state_word;
        end

        if (cmd.accept)
        begin
            rnd_reg  <= items.random_value;
            rem_reg  <= '0;
            divc_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rnd_reg  <= rnd_reg << 1;
            divc_reg <= divc_reg + hrb_pkg::DIVC_W'(1);
            if (div_t >= {1'b0, fill_reg})
            begin
                rem_reg <= CNT_W'(div_t - {1'b0, fill_reg});
            end
            else
            begin
                rem_reg <= CNT_W'(div_t);
            end
        end

        if (cmd.set_sample || cmd.set_recent)
        begin
            stopped_reg <= 1'b0;
            j_reg       <= '0;
            phase_reg   <= 1'b0;
            f_reg       <= '0;
            w_reg       <= '0;
            recent_reg  <= cmd.set_recent;
        end

        if (cmd.set_sample)
        begin
            pos_reg   <= s_val;
            avail_reg <= older_val;
            nxt_reg   <= (CNT_W'(s_val) + CNT_W'(1) == cap_reg) ? '0 : s_val + PTR_W'(1);
            sel_idx_reg[SW'(h_eff - FW'(1))] <= s_val;
            sel_ok_reg[SW'(h_eff - FW'(1))]  <= 1'b1;
        end

        if (cmd.set_recent)
        begin
            pos_reg       <= wp_reg;
            avail_reg     <= fill_reg;
            zero_next_reg <= 1'b0;
            meta_act_reg  <= '0;
            meta_rew_reg  <= '0;
            meta_done_reg <= 1'b0;
        end

        if (cmd.load_meta)
        begin
            meta_act_reg  <= entry_rdata[hrb_pkg::META_W-1 -: 16];
            meta_rew_reg  <= entry_rdata[32:1];
            meta_done_reg <= entry_rdata[0];
            zero_next_reg <= entry_rdata[0] || (nxt_reg == wp_reg);
        end

        if (cmd.walk_issue)
        begin
            prev_reg <= prev_val;
        end

        if (cmd.walk_pad)
        begin
            sel_ok_reg[walk_slot] <= 1'b0;
            j_reg                 <= j_reg + FW'(1);
        end

        if (cmd.walk_check)
        begin
            j_reg <= j_reg + FW'(1);
            if (entry_rdata[0])
            begin
                stopped_reg           <= 1'b1;
                sel_ok_reg[walk_slot] <= 1'b0;
            end
            else
            begin
                sel_ok_reg[walk_slot]  <= 1'b1;
                sel_idx_reg[walk_slot] <= prev_reg;
                pos_reg                <= prev_reg;
                avail_reg              <= avail_reg - CNT_W'(1);
            end
        end

        if (cmd.emit_load)
        begin
            out_kind_reg <= recent_reg ? hrb_pkg::KIND_RECENT
                            : (phase_reg ? hrb_pkg::KIND_NEXT : hrb_pkg::KIND_HIST);
            out_slot_reg <= f_reg[1:0];
            out_word_reg <= 2'(w_reg);
            out_data_reg <= src_cur ? curbuf_reg[w_reg] : (e_ok ? state_rdata : '0);
            out_act_reg  <= meta_act_reg;
            out_rew_reg  <= meta_rew_reg;
            out_done_reg <= meta_done_reg;
            out_last_reg <= emit_last;
        end
        else if (cmd.err_load)
        begin
            out_kind_reg <= hrb_pkg::KIND_EMPTY;
            out_slot_reg <= '0;
            out_word_reg <= '0;
            out_data_reg <= '0;
            out_act_reg  <= '0;
            out_rew_reg  <= '0;
            out_done_reg <= 1'b0;
            out_last_reg <= 1'b1;
        end

        if (cmd.emit_advance)
        begin
            if (w_reg == WORD_LAST)
            begin
                w_reg <= '0;
                if (last_frame)
                begin
                    f_reg     <= '0;
                    phase_reg <= 1'b1;
                end
                else
                begin
                    f_reg <= f_reg + FW'(1);
                end
            end
            else
            begin
                w_reg <= w_reg + WORD_W'(1);
            end
        end
    end

    assign status.in_act        = items.action;
    assign status.fill_zero     = (fill_reg == '0);
    assign status.recent_final  = (items.action == hrb_pkg::ACT_RECENT) && (rec_wc_reg == WORD_LAST);
    assign status.div_done      = (divc_reg == hrb_pkg::DIVC_W'(hrb_pkg::RND_W));
    assign status.walk_done     = (j_reg == h_eff - FW'(1));
    assign status.walk_can_read = !stopped_reg && (avail_reg != '0);
    assign status.out_taken     = out_taken;
    assign status.out_last      = out_last_reg;

    assign results.valid         = out_valid_reg;
    assign results.kind          = out_kind_reg;
    assign results.frame_slot    = out_slot_reg;
    assign results.word_index    = out_word_reg;
    assign results.data_word     = out_data_reg;
    assign results.sample_action = out_act_reg;
    assign results.sample_reward = out_rew_reg;
    assign results.sample_done   = out_done_reg;
    assign results.last          = out_last_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/history_replay_buffer_top.sv =====
`default_nettype none
// Ring store of transitions, one request at a time. An add or a non-final recent word is
// stored on acceptance with no further steps. On an empty ring a sample gives one empty
// result. Otherwise it reduces the random value modulo the fill count, fetches the entry,
// walks the earlier history frames through the done flags, then emits each word of a
// history window and a next window by a state memory read, an output register load and a
// handshake. The final recent word has no division, no entry fetch and a single window.
// Each memory has a single read port, so the walk and the result words read one entry at
// a time.
module history_replay_buffer_top #(
    parameter int BUFFER_DEPTH = hrb_pkg::BUFFER_DEPTH_DEF,
    parameter int STATE_WORDS  = hrb_pkg::STATE_WORDS_DEF,
    parameter int HISTORY_MAX  = hrb_pkg::HISTORY_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    hrb_in_if.sink                              items,
    hrb_out_if.source                           results,
    input  wire logic                           wr_en,
    input  wire logic [hrb_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [hrb_pkg::CFG_DATA_W-1:0] wr_data
);

    hrb_pkg::hrb_cmd_t    cmd;
    hrb_pkg::hrb_status_t status;

    hrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .status   (status),
        .cmd      (cmd)
    );

    hrb_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .STATE_WORDS  (STATE_WORDS),
        .HISTORY_MAX  (HISTORY_MAX)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .results  (results),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cmd      (cmd),
        .status   (status)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(results.valid && items.ready))
        else $error("result pending while a new request is accepted");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.kind == hrb_pkg::KIND_EMPTY) |-> results.last)
        else $error("empty result is not final");

    a_recent_meta: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.kind == hrb_pkg::KIND_RECENT) |->
        (results.sample_action == '0) && !results.sample_done)
        else $error("recent window carries sample fields");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
    import hrb_pkg::*;

    localparam int DEPTH = BUFFER_DEPTH_DEF;
    localparam int WORDS = STATE_WORDS_DEF;
    localparam int HMAX  = HISTORY_MAX_DEF;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] state_word;
        logic [15:0] taken_action;
        logic [31:0] reward_bits;
        logic        done_flag;
        logic [15:0] random_value;
        bit          typed_empty;
    } request_t;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  frame_slot;
        logic [1:0]  word_index;
        logic [31:0] data_word;
        logic [15:0] sample_action;
        logic [31:0] sample_reward;
        logic        sample_done;
        logic        last;
    } frame_word_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    hrb_in_if  items ();
    hrb_out_if results ();

    history_replay_buffer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items.sink),
        .results  (results.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Shadow of the ring contents and pointers.
    logic [31:0] state_mem [DEPTH][WORDS];
    logic [15:0] action_mem [DEPTH];
    logic [31:0] reward_mem [DEPTH];
    logic        done_mem [DEPTH];
    logic [31:0] current_frame [WORDS];
    int          write_ptr;
    int          fill_count;
    int          add_pos;
    int          recent_pos;
    int          hist_reg;
    int          ring_size;
    int          window_entry [HMAX];

    frame_word_t pending_words [$];
    int          error_count;
    bit          idling_on;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = 1'b1;
            #4 clk = 1'b0;
        end
    end

    initial
    begin
        #16000000;
        $display("history_replay_buffer_top verification failed");
        $finish;
    end

    function automatic int window_frames();
        if (hist_reg < 1)
            return 1;
        if (hist_reg > HMAX)
            return HMAX;
        return hist_reg;
    endfunction

    // Fills window_entry[top], window_entry[top-1], ... with predecessors; -1 is padding.
    function automatic void walk_history(int pos, int avail, int top, int count);
        bit stopped;
        int prev;
        stopped = 0;
        for (int j = 0; j < count; j++)
        begin
            window_entry[top - j] = -1;
            if (!stopped && avail > 0)
            begin
                prev = (pos + ring_size - 1) % ring_size;
                if (done_mem[prev])
                    stopped = 1;
                else
                begin
                    window_entry[top - j] = prev;
                    pos = prev;
                    avail--;
                end
            end
        end
    endfunction

    function automatic logic [31:0] stored_word(int entry, int w);
        if (entry < 0)
            return 32'd0;
        return state_mem[entry][w];
    endfunction

    function automatic void push_word(logic [1:0] kind, int slot, int w, logic [31:0] data,
                                      logic [15:0] act, logic [31:0] rew, logic dn);
        frame_word_t r;
        r.kind = kind;
        r.frame_slot = slot[1:0];
        r.word_index = w[1:0];
        r.data_word = data;
        r.sample_action = act;
        r.sample_reward = rew;
        r.sample_done = dn;
        r.last = 1'b0;
        pending_words.push_back(r);
    endfunction

    function automatic void predict_request(request_t rq);
        int h;
        int s;
        int older;
        int nxt;
        int e;
        bit zero_next;
        h = window_frames();
        case (rq.action)
            ACT_ADD:
            begin
                state_mem[write_ptr][add_pos] = rq.state_word;
                if (add_pos == WORDS - 1)
                begin
                    action_mem[write_ptr] = rq.taken_action;
                    reward_mem[write_ptr] = rq.reward_bits;
                    done_mem[write_ptr] = rq.done_flag;
                    write_ptr = (write_ptr + 1) % ring_size;
                    if (fill_count < ring_size)
                        fill_count++;
                    add_pos = 0;
                end
                else
                    add_pos++;
            end
            ACT_SAMPLE:
            begin
                if (fill_count == 0)
                    push_word(KIND_EMPTY, 0, 0, 32'd0, 16'd0, 32'd0, 1'b0);
                else
                begin
                    s = int'(rq.random_value) % fill_count;
                    older = (fill_count == ring_size) ?
                            (s + ring_size - write_ptr) % ring_size : s;
                    window_entry[h - 1] = s;
                    walk_history(s, older, h - 2, h - 1);
                    for (int f = 0; f < h; f++)
                        for (int w = 0; w < WORDS; w++)
                            push_word(KIND_HIST, f, w, stored_word(window_entry[f], w),
                                      action_mem[s], reward_mem[s], done_mem[s]);
                    nxt = (s + 1) % ring_size;
                    zero_next = done_mem[s] || nxt == write_ptr;
                    for (int f = 0; f < h; f++)
                    begin
                        e = zero_next ? -1 : (f == h - 1 ? nxt : window_entry[f + 1]);
                        for (int w = 0; w < WORDS; w++)
                            push_word(KIND_NEXT, f, w, stored_word(e, w),
                                      action_mem[s], reward_mem[s], done_mem[s]);
                    end
                end
                pending_words[pending_words.size() - 1].last = 1'b1;
            end
            ACT_RECENT:
            begin
                current_frame[recent_pos] = rq.state_word;
                if (recent_pos < WORDS - 1)
                    recent_pos++;
                else
                begin
                    recent_pos = 0;
                    walk_history(write_ptr, fill_count, h - 2, h - 1);
                    for (int f = 0; f < h; f++)
                        for (int w = 0; w < WORDS; w++)
                            push_word(KIND_RECENT, f, w, (f == h - 1) ? current_frame[w] :
                                      stored_word(window_entry[f], w), 16'd0, 32'd0, 1'b0);
                    pending_words[pending_words.size() - 1].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_request(request_t rq);
        frame_word_t r;
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 11);
        repeat (gap)
        begin
            @(negedge clk);
            items.valid <= 1'b0;
        end
        @(negedge clk);
        items.valid <= 1'b1;
        items.action <= rq.action;
        items.state_word <= rq.state_word;
        items.taken_action <= rq.taken_action;
        items.reward_bits <= rq.reward_bits;
        items.done_flag <= rq.done_flag;
        items.random_value <= rq.random_value;
        do
            @(posedge clk);
        while (!items.ready);
        if (rq.typed_empty)
        begin
            r = '{KIND_EMPTY, 2'd0, 2'd0, 32'd0, 16'd0, 32'd0, 1'b0, 1'b1};
            pending_words.push_back(r);
        end
        else
            predict_request(rq);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        items.valid <= 1'b0;
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == REG_HISTORY_LEN)
            hist_reg = value & 7;
        else
        begin
            ring_size = value & 11'h7ff;
            if (ring_size < 1)
                ring_size = 1;
            if (ring_size > DEPTH)
                ring_size = DEPTH;
            write_ptr = 0;
            fill_count = 0;
            add_pos = 0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        items.valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    function automatic request_t make_request(logic [1:0] act, logic [31:0] sw,
                                              logic dn);
        request_t rq;
        rq.action = act;
        rq.state_word = sw;
        rq.taken_action = 16'($urandom);
        rq.reward_bits = $urandom;
        rq.done_flag = dn;
        rq.random_value = 16'($urandom);
        rq.typed_empty = 0;
        return rq;
    endfunction

    // Receiver side: random stalls plus one long hold-off on request.
    initial
    begin
        int stall;
        stall = 0;
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                results.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_request = 0;
                results.ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                results.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 10);
                results.ready <= 1'b0;
            end
            else
                results.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        frame_word_t exp_w;
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d data=%h", $time, results.kind,
                         results.data_word);
                error_count++;
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (exp_w.kind !== results.kind || exp_w.frame_slot !== results.frame_slot
                    || exp_w.word_index !== results.word_index
                    || exp_w.data_word !== results.data_word
                    || exp_w.sample_action !== results.sample_action
                    || exp_w.sample_reward !== results.sample_reward
                    || exp_w.sample_done !== results.sample_done
                    || exp_w.last !== results.last)
                begin
                    $display("%0t: expected k%0d s%0d w%0d d=%h a=%h r=%h dn=%b l=%b",
                             $time, exp_w.kind, exp_w.frame_slot, exp_w.word_index,
                             exp_w.data_word, exp_w.sample_action, exp_w.sample_reward,
                             exp_w.sample_done, exp_w.last);
                    $display("%0t: actual   k%0d s%0d w%0d d=%h a=%h r=%h dn=%b l=%b",
                             $time, results.kind, results.frame_slot, results.word_index,
                             results.data_word, results.sample_action,
                             results.sample_reward, results.sample_done, results.last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        request_t directed [20];
        request_t rq;
        int hist_values [6];
        int cap_values [6];
        int sent;
        int pick;
        logic dn;

        error_count = 0;
        idling_on = 1;
        hold_request = 0;
        write_ptr = 0;
        fill_count = 0;
        add_pos = 0;
        recent_pos = 0;
        hist_reg = 4;
        ring_size = DEPTH;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        items.valid = 1'b0;
        items.action = ACT_ADD;
        items.state_word = '0;
        items.taken_action = '0;
        items.reward_bits = '0;
        items.done_flag = 1'b0;
        items.random_value = '0;

        // Empty sample, ignored action, recent on an empty ring, extreme entries.
        directed[0] = '{ACT_SAMPLE, 32'h0, 16'h0, 32'h0, 1'b0, 16'hffff, 1};
        directed[1] = '{2'd3, 32'hffffffff, 16'hffff, 32'hffffffff, 1'b1, 16'hffff, 0};
        for (int i = 2; i < 6; i++)
            directed[i] = '{ACT_RECENT, 32'h8000_0001 + i, 16'h0, 32'h0, 1'b0, 16'h0, 0};
        for (int i = 6; i < 10; i++)
            directed[i] = '{ACT_ADD, 32'hffffffff, 16'hffff, 32'hffffffff, 1'b0, 16'h0, 0};
        for (int i = 10; i < 14; i++)
            directed[i] = '{ACT_ADD, 32'h0, 16'h0, 32'h0, 1'b1, 16'h0, 0};
        directed[14] = '{ACT_SAMPLE, 32'h0, 16'h0, 32'h0, 1'b0, 16'hffff, 0};
        directed[15] = '{ACT_SAMPLE, 32'h0, 16'h0, 32'h0, 1'b0, 16'h0, 0};
        for (int i = 16; i < 20; i++)
            directed[i] = '{ACT_RECENT, 32'h5a5a_0000 + i, 16'h0, 32'h0, 1'b0, 16'h0, 0};

        hist_values = '{0, 2, 7, 1, 3, 4};
        cap_values  = '{1, 2, 5, 0, 2047, 1024};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_request(directed[i]);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_register(REG_HISTORY_LEN, hist_values[phase]);
            write_register(REG_CAPACITY, cap_values[phase]);
            if (phase == 5)
                idling_on = 0;
            if (phase == 3)
                hold_request = 1;
            sent = 0;
            while (sent < 65)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    dn = ($urandom_range(0, 4) == 0);
                    for (int w = 0; w < WORDS; w++)
                    begin
                        rq = make_request(ACT_ADD, $urandom, dn);
                        send_request(rq);
                    end
                    sent += WORDS;
                end
                else if (pick < 7)
                begin
                    send_request(make_request(ACT_SAMPLE, $urandom, 1'b0));
                    sent++;
                end
                else if (pick < 9)
                begin
                    for (int w = 0; w < WORDS; w++)
                        send_request(make_request(ACT_RECENT, $urandom,
                                                  1'($urandom_range(0, 1))));
                    sent += WORDS;
                end
                else
                begin
                    rq = make_request(2'($urandom_range(0, 3)), $urandom,
                                      1'($urandom_range(0, 1)));
                    send_request(rq);
                    if (rq.action != 2'd3)
                        sent++;
                end
            end
            drain();
        end

        if (error_count == 0)
            $display("history_replay_buffer_top verification clean");
        else
            $display("history_replay_buffer_top verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/hrb_pkg.sv
hw/rtl/hrb_in_if.sv
hw/rtl/hrb_out_if.sv
hw/rtl/hrb_ram.sv
hw/rtl/hrb_ctrl.sv
hw/rtl/hrb_dp.sv
hw/rtl/history_replay_buffer_top.sv
dv/tb.sv
